// ===== sv/pmt_section_parser_defines.svh =====
// Assertion macros for the PMT section parser.
// Used by files that check their own logic; expects clk and arst_n in scope.
`ifndef PMT_SECTION_PARSER_DEFINES_SVH
`define PMT_SECTION_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define PSP_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pmt_section_parser: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define PSP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pmt_section_parser: next-cycle check failed");

`endif

// ===== sv/psp_pkg.sv =====
// Shared types and constants for the PMT section parser.
// No dependencies; compiled before the interface and the top level.
`default_nettype none

package psp_pkg;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned CFG_WIDTH  = 8;

	localparam logic [9:0] HEADER_AND_CRC  = 10'd9;
	localparam logic [9:0] MIN_SECTION_LEN = 10'd13;
	localparam logic [9:0] MIN_ENTRY_BYTES = 10'd5;

	typedef enum logic [1:0] {
		KIND_PCR  = 2'd0,
		KIND_ES   = 2'd1,
		KIND_DONE = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_PES      = 2'd0,
		CLASS_SECTIONS = 2'd1,
		CLASS_PRIVATE  = 2'd2
	} pid_class_t;

	typedef enum logic {
		CFG_PRIV_SECTIONS = 1'b0,
		CFG_PRIV_DATA     = 1'b1
	} cfg_index_t;

	typedef enum logic [10:0] {
		PH_IDLE      = 11'b000_0000_0001,
		PH_PCR_LO    = 11'b000_0000_0010,
		PH_DESC_HI   = 11'b000_0000_0100,
		PH_DESC_LO   = 11'b000_0000_1000,
		PH_SKIP_DESC = 11'b000_0001_0000,
		PH_ES_TYPE   = 11'b000_0010_0000,
		PH_ES_PID_HI = 11'b000_0100_0000,
		PH_ES_PID_LO = 11'b000_1000_0000,
		PH_INFO_HI   = 11'b001_0000_0000,
		PH_INFO_LO   = 11'b010_0000_0000,
		PH_SKIP_INFO = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic [9:0] section_length;
	} byte_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [12:0] pid;
		logic [7:0] stream_type;
		pid_class_t pid_class;
		logic       last_of_run;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/psp_stream_if.sv =====
// Valid/ready stream channel carrying one payload item of type T.
// No dependencies; the payload type is supplied where the channel is declared.
`default_nettype none

interface psp_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== sv/pmt_section_parser.sv =====
// PMT section body parser: byte stream in, PCR/ES/done/error items out.
// Depends on psp_pkg, psp_stream_if and pmt_section_parser_defines.svh.
//
//   Channel   Dir  Handshake          Payload
//   bytes     in   valid/ready        data_byte, first_byte, section_length
//   results   out  valid/ready        kind, pid, stream_type, pid_class, last_of_run
//   cfg_*     in   write enable only  cfg_index, cfg_data
//
// One byte is accepted per cycle while bytes.ready is high; it is parsed in the cycle
// after acceptance and its results enter an OUT_DEPTH-entry result FIFO.
// A byte can make two results while one result leaves per pop, so the output rate sets
// the long-run rate; bytes.ready drops while fewer than four FIFO entries are free.
// Reset returns the parser to idle, empties the FIFO and loads the type registers.
`default_nettype none

`include "pmt_section_parser_defines.svh"

module pmt_section_parser #(
	parameter int unsigned OUT_DEPTH = psp_pkg::FIFO_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	psp_stream_if.sink                          bytes,
	psp_stream_if.source                        results,
	input  wire logic                           cfg_we,
	input  wire psp_pkg::cfg_index_t            cfg_index,
	input  wire logic [psp_pkg::CFG_WIDTH-1:0]  cfg_data
);
	import psp_pkg::*;

	localparam int unsigned PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(OUT_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic [12:0] p,
			input logic [7:0] t, input pid_class_t c);
		result_t r;
		r.kind        = k;
		r.pid         = p;
		r.stream_type = t;
		r.pid_class   = c;
		r.last_of_run = 1'b0;
		mk_result = r;
	endfunction

	// Configuration
	logic [7:0] priv_sections_q;
	logic [7:0] priv_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priv_sections_q <= 8'd5;
			priv_data_q     <= 8'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRIV_SECTIONS: priv_sections_q <= cfg_data[7:0];
				CFG_PRIV_DATA:     priv_data_q     <= cfg_data[7:0];
				default:           priv_sections_q <= priv_sections_q;
			endcase
		end
	end

	// Input stage
	logic       valid_s1;
	byte_item_t item_s1;
	logic       accept;
	logic [CW-1:0] count_q;

	// Room is kept for the item in the parse stage and the one being accepted.
	assign bytes.ready = (32'(count_q) + 32'd4) <= OUT_DEPTH;
	assign accept      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= bytes.data;
		end
	end

	// Parser state
	phase_t      phase_q, phase_d;
	logic [9:0]  bytes_left_q, bytes_left_d;
	logic [11:0] skip_q, skip_d;
	logic [7:0]  held_type_q, held_type_d;
	logic [12:0] held_pid_q, held_pid_d;
	logic [3:0]  held_high_q, held_high_d;

	result_t    res0, res1;
	logic [1:0] n_push;
	logic [9:0] bl_dec;
	logic [11:0] skip_dec;
	logic [11:0] len_field;
	pid_class_t es_class;
	kind_t      last_kind;

	assign bl_dec    = bytes_left_q - 10'd1;
	assign skip_dec  = (skip_q != 12'd0) ? skip_q - 12'd1 : skip_q;
	assign len_field = {held_high_q, item_s1.data_byte};

	always_comb begin
		if (held_type_q == priv_sections_q) begin
			es_class = CLASS_SECTIONS;
		end else if (held_type_q == priv_data_q) begin
			es_class = CLASS_PRIVATE;
		end else begin
			es_class = CLASS_PES;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		skip_d       = skip_q;
		held_type_d  = held_type_q;
		held_pid_d   = held_pid_q;
		held_high_d  = held_high_q;
		res0         = mk_result(KIND_ERR, 13'd0, 8'd0, CLASS_PES);
		res1         = mk_result(KIND_ERR, 13'd0, 8'd0, CLASS_PES);
		n_push       = 2'd0;

		if (valid_s1) begin
			if (item_s1.first_byte) begin
				if (item_s1.section_length < MIN_SECTION_LEN) begin
					phase_d = PH_IDLE;
					n_push  = 2'd1;
				end else begin
					bytes_left_d = item_s1.section_length - HEADER_AND_CRC - 10'd1;
					skip_d       = 12'd0;
					held_type_d  = 8'd0;
					held_high_d  = 4'd0;
					held_pid_d   = {8'd0, item_s1.data_byte[4:0]};
					phase_d      = PH_PCR_LO;
				end
			end else if (phase_q != PH_IDLE) begin
				if (bytes_left_q == 10'd0 ||
						(phase_q == PH_ES_TYPE && bytes_left_q < MIN_ENTRY_BYTES)) begin
					phase_d = PH_IDLE;
					n_push  = 2'd1;
				end else begin
					bytes_left_d = bl_dec;
					unique case (phase_q)
						PH_PCR_LO: begin
							held_pid_d = {held_pid_q[4:0], item_s1.data_byte};
							res0       = mk_result(KIND_PCR, {held_pid_q[4:0],
								item_s1.data_byte}, 8'd0, CLASS_PES);
							n_push     = 2'd1;
							phase_d    = PH_DESC_HI;
						end
						PH_DESC_HI, PH_INFO_HI: begin
							held_high_d = item_s1.data_byte[3:0];
							phase_d     = (phase_q == PH_DESC_HI) ? PH_DESC_LO : PH_INFO_LO;
						end
						PH_DESC_LO: begin
							skip_d = len_field;
							if (len_field > {2'b00, bl_dec}) begin
								phase_d = PH_IDLE;
								n_push  = 2'd1;
							end else if (len_field != 12'd0) begin
								phase_d = PH_SKIP_DESC;
							end else if (bl_dec == 10'd0) begin
								phase_d = PH_IDLE;
								res0    = mk_result(KIND_DONE, 13'd0, 8'd0, CLASS_PES);
								n_push  = 2'd1;
							end else begin
								phase_d = PH_ES_TYPE;
							end
						end
						PH_SKIP_DESC, PH_SKIP_INFO: begin
							skip_d = skip_dec;
							if (skip_dec == 12'd0) begin
								if (bl_dec == 10'd0) begin
									phase_d = PH_IDLE;
									res0    = mk_result(KIND_DONE, 13'd0, 8'd0, CLASS_PES);
									n_push  = 2'd1;
								end else begin
									phase_d = PH_ES_TYPE;
								end
							end
						end
						PH_ES_TYPE: begin
							held_type_d = item_s1.data_byte;
							phase_d     = PH_ES_PID_HI;
						end
						PH_ES_PID_HI: begin
							held_pid_d = {8'd0, item_s1.data_byte[4:0]};
							phase_d    = PH_ES_PID_LO;
						end
						PH_ES_PID_LO: begin
							held_pid_d = {held_pid_q[4:0], item_s1.data_byte};
							phase_d    = PH_INFO_HI;
						end
						PH_INFO_LO: begin
							// The entry goes out first; an overrun or the body end follows it.
							skip_d = len_field;
							res0   = mk_result(KIND_ES, held_pid_q, held_type_q, es_class);
							n_push = 2'd1;
							if (len_field > {2'b00, bl_dec}) begin
								phase_d = PH_IDLE;
								n_push  = 2'd2;
							end else if (len_field != 12'd0) begin
								phase_d = PH_SKIP_INFO;
							end else if (bl_dec == 10'd0) begin
								phase_d = PH_IDLE;
								res1    = mk_result(KIND_DONE, 13'd0, 8'd0, CLASS_PES);
								n_push  = 2'd2;
							end else begin
								phase_d = PH_ES_TYPE;
							end
						end
						default: begin
							phase_d = PH_IDLE;
							n_push  = 2'd1;
						end
					endcase
				end
			end
		end

		res0.last_of_run = (n_push == 2'd1);
		res1.last_of_run = 1'b1;
	end

	assign last_kind = (n_push == 2'd2) ? res1.kind : res0.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bytes_left_q <= 10'd0;
			skip_q       <= 12'd0;
			held_type_q  <= 8'd0;
			held_pid_q   <= 13'd0;
			held_high_q  <= 4'd0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			skip_q       <= skip_d;
			held_type_q  <= held_type_d;
			held_pid_q   <= held_pid_d;
			held_high_q  <= held_high_d;
		end
	end

	// Result FIFO
	result_t       fifo_q [OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW-1:0] wr_ptr_p1;
	logic          pop;

	assign wr_ptr_p1     = ptr_inc(wr_ptr_q);
	assign pop           = results.valid && results.ready;
	assign results.valid = (count_q != '0);
	assign results.data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_p1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (n_push == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (n_push == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	// Checks
	`PSP_ASSERT_NEXT(a_error_goes_idle, valid_s1 && n_push != 2'd0 && last_kind == KIND_ERR, phase_q == PH_IDLE)
	`PSP_ASSERT_NEXT(a_bytes_left_falls, valid_s1 && !item_s1.first_byte, bytes_left_q <= $past(bytes_left_q))
	`PSP_ASSERT_IMPL(a_fifo_room, valid_s1, (32'(count_q) + 32'(n_push)) <= OUT_DEPTH)
	`PSP_ASSERT_IMPL(a_fifo_bounded, 1'b1, 32'(count_q) <= OUT_DEPTH)

endmodule

`default_nettype wire

// ===== tb/sv/pmt_parse_monitor.sv =====
// Result monitor for the PMT section parser: follows the byte and result channels,
// predicts each result from the accepted bytes and compares them field by field.
// Depends on psp_pkg for the item, result, kind, class, phase and register types.
module pmt_parse_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	input  logic                           byte_ready,
	input  psp_pkg::byte_item_t            byte_data,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  psp_pkg::result_t               res_data,
	input  logic                           cfg_we,
	input  psp_pkg::cfg_index_t            cfg_index,
	input  logic [psp_pkg::CFG_WIDTH-1:0]  cfg_data,
	output int                             mismatches,
	output int                             outstanding,
	output int                             bytes_taken,
	output int                             results_taken,
	output int                             length_errors
);
	import psp_pkg::*;

	phase_t      phase;
	logic [9:0]  left;
	logic [11:0] skip;
	logic [7:0]  es_type;
	logic [12:0] es_pid;
	logic [3:0]  len_hi;
	logic [7:0]  sections_code;
	logic [7:0]  private_code;
	result_t     expected_results[$];
	result_t     byte_out[$];
	int          fail_tally;
	int          byte_tally;
	int          result_tally;
	int          error_tally;

	function automatic pid_class_t class_for(input logic [7:0] t);
		if (t == sections_code) return CLASS_SECTIONS;
		if (t == private_code) return CLASS_PRIVATE;
		return CLASS_PES;
	endfunction

	function automatic void note(input kind_t k, input logic [12:0] p, input logic [7:0] st,
			input pid_class_t c);
		result_t r;
		r.kind = k;
		r.pid = p;
		r.stream_type = st;
		r.pid_class = c;
		r.last_of_run = 1'b0;
		byte_out.push_back(r);
	endfunction

	function automatic void length_error();
		phase = PH_IDLE;
		note(KIND_ERR, '0, '0, CLASS_PES);
	endfunction

	// A block of descriptors or ES info has ended: either the body is used up
	// or another entry follows.
	function automatic void end_of_block();
		if (left == 10'd0) begin
			phase = PH_IDLE;
			note(KIND_DONE, '0, '0, CLASS_PES);
		end else begin
			phase = PH_ES_TYPE;
		end
	endfunction

	function automatic void parse_pmt_byte(input byte_item_t it);
		logic [7:0] b;
		b = it.data_byte;
		byte_out = {};
		if (it.first_byte) begin
			if (it.section_length < MIN_SECTION_LEN) begin
				length_error();
			end else begin
				left = it.section_length - HEADER_AND_CRC - 10'd1;
				skip = '0;
				es_type = '0;
				len_hi = '0;
				es_pid = {8'd0, b[4:0]};
				phase = PH_PCR_LO;
			end
		end else if (phase != PH_IDLE) begin
			if (left == 10'd0 || (phase == PH_ES_TYPE && left < MIN_ENTRY_BYTES)) begin
				length_error();
			end else begin
				left = left - 10'd1;
				case (phase)
				PH_PCR_LO: begin
					es_pid = {es_pid[4:0], b};
					note(KIND_PCR, es_pid, '0, CLASS_PES);
					phase = PH_DESC_HI;
				end
				PH_DESC_HI: begin
					len_hi = b[3:0];
					phase = PH_DESC_LO;
				end
				PH_DESC_LO: begin
					skip = {len_hi, b};
					if (skip > {2'b00, left}) length_error();
					else if (skip != 12'd0) phase = PH_SKIP_DESC;
					else end_of_block();
				end
				PH_SKIP_DESC, PH_SKIP_INFO: begin
					if (skip != 12'd0) skip = skip - 12'd1;
					if (skip == 12'd0) end_of_block();
				end
				PH_ES_TYPE: begin
					es_type = b;
					phase = PH_ES_PID_HI;
				end
				PH_ES_PID_HI: begin
					es_pid = {8'd0, b[4:0]};
					phase = PH_ES_PID_LO;
				end
				PH_ES_PID_LO: begin
					es_pid = {es_pid[4:0], b};
					phase = PH_INFO_HI;
				end
				PH_INFO_HI: begin
					len_hi = b[3:0];
					phase = PH_INFO_LO;
				end
				PH_INFO_LO: begin
					skip = {len_hi, b};
					note(KIND_ES, es_pid, es_type, class_for(es_type));
					if (skip > {2'b00, left}) length_error();
					else if (skip != 12'd0) phase = PH_SKIP_INFO;
					else end_of_block();
				end
				default: begin
					length_error();
				end
				endcase
			end
		end
		if (byte_out.size() > 0) byte_out[byte_out.size() - 1].last_of_run = 1'b1;
		foreach (byte_out[i]) expected_results.push_back(byte_out[i]);
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result: kind %0d pid %0d stream_type %0d pid_class %0d",
				got.kind, got.pid, got.stream_type, got.pid_class);
			fail_tally++;
			return;
		end
		want = expected_results.pop_front();
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			fail_tally++;
		end
		if (got.pid !== want.pid) begin
			$error("pid: expected %0d, got %0d", want.pid, got.pid);
			fail_tally++;
		end
		if (got.stream_type !== want.stream_type) begin
			$error("stream_type: expected %0d, got %0d", want.stream_type, got.stream_type);
			fail_tally++;
		end
		if (got.pid_class !== want.pid_class) begin
			$error("pid_class: expected %0d, got %0d", want.pid_class, got.pid_class);
			fail_tally++;
		end
		if (got.last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
			fail_tally++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			left = '0;
			skip = '0;
			es_type = '0;
			es_pid = '0;
			len_hi = '0;
			sections_code = 8'd5;
			private_code = 8'd6;
			expected_results = {};
			fail_tally = 0;
			byte_tally = 0;
			result_tally = 0;
			error_tally = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_PRIV_SECTIONS: sections_code = cfg_data;
				CFG_PRIV_DATA:     private_code = cfg_data;
				default: ;
				endcase
			end
			if (byte_valid && byte_ready) begin
				parse_pmt_byte(byte_data);
				byte_tally++;
			end
			if (res_valid && res_ready) begin
				check_result(res_data);
				result_tally++;
				if (res_data.kind == KIND_ERR) error_tally++;
			end
		end
		mismatches <= fail_tally;
		outstanding <= expected_results.size();
		bytes_taken <= byte_tally;
		results_taken <= result_tally;
		length_errors <= error_tally;
	end

endmodule

// ===== tb/sv/pmt_section_parser_tb.sv =====
// Top of the PMT section parser testbench: clock, reset, byte stimulus, result
// back-pressure, type register writes and the verdict.
// Depends on psp_pkg, psp_stream_if, pmt_section_parser and pmt_parse_monitor.
module pmt_section_parser_tb;
	import psp_pkg::*;

	localparam int PHASE_ITEMS    = 96;
	localparam int PHASE_COUNT    = 7;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_index_t           cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	psp_stream_if #(.T(byte_item_t)) byte_ch ();
	psp_stream_if #(.T(result_t))    result_ch ();

	int         mismatches;
	int         outstanding;
	int         bytes_taken;
	int         results_taken;
	int         length_errors;
	int         items_sent;
	int         settings_used;
	int         idle_cycles;
	int         ready_hold;
	logic       calm;
	logic [7:0] sections_code;
	logic [7:0] private_code;
	byte_item_t section_bytes[$];

	pmt_section_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pmt_parse_monitor parse_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_ch.valid),
		.byte_ready    (byte_ch.ready),
		.byte_data     (byte_ch.data),
		.res_valid     (result_ch.valid),
		.res_ready     (result_ch.ready),
		.res_data      (result_ch.data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.bytes_taken   (bytes_taken),
		.results_taken (results_taken),
		.length_errors (length_errors)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] rand_byte();
		logic [31:0] rnd;
		rnd = $urandom;
		return rnd[7:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Most entries carry one of the two programmed codes so that every class shows up.
	function automatic logic [7:0] pick_stream_type();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return sections_code;
		if (r < 60) return private_code;
		return rand_byte();
	endfunction

	function automatic void add_body_byte(input logic [7:0] b);
		byte_item_t it;
		logic [31:0] rnd;
		rnd = $urandom;
		it.data_byte = b;
		it.first_byte = 1'b0;
		it.section_length = rnd[9:0];
		section_bytes.push_back(it);
	endfunction

	function automatic int claimed_len(input int adj);
		int full;
		full = section_bytes.size() + 9 + adj;
		if (full < 0) full = 0;
		if (full > 1023) full = 1023;
		return full;
	endfunction

	// Builds a section body. With wild set, one length field (descriptors or one of
	// the entries) gets a random 12-bit value that need not match the bytes behind it.
	function automatic void build_section(input int n_es, input int desc_len,
			input int info_max, input logic wild);
		logic [31:0] rnd;
		logic [12:0] pid;
		logic [11:0] field;
		int          wild_at;
		int          ilen;
		int          e;
		section_bytes = {};
		wild_at = wild ? $urandom_range(0, n_es) : -1;
		rnd = $urandom;
		pid = rnd[12:0];
		add_body_byte({rnd[31:29], pid[12:8]});
		add_body_byte(pid[7:0]);
		rnd = $urandom;
		field = (wild_at == 0) ? rnd[11:0] : desc_len[11:0];
		add_body_byte({rnd[31:28], field[11:8]});
		add_body_byte(field[7:0]);
		repeat (desc_len) add_body_byte(rand_byte());
		for (e = 1; e <= n_es; e++) begin
			ilen = $urandom_range(0, info_max);
			add_body_byte(pick_stream_type());
			rnd = $urandom;
			pid = rnd[12:0];
			add_body_byte({rnd[31:29], pid[12:8]});
			add_body_byte(pid[7:0]);
			rnd = $urandom;
			field = (wild_at == e) ? rnd[11:0] : ilen[11:0];
			add_body_byte({rnd[31:28], field[11:8]});
			add_body_byte(field[7:0]);
			repeat (ilen) add_body_byte(rand_byte());
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_byte(input byte_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.data <= it;
		byte_ch.valid <= 1'b1;
		do @(posedge clk); while (!byte_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_queued(input int count);
		int i;
		calm = ($urandom_range(0, 7) == 0);
		for (i = 0; i < count; i++) send_byte(section_bytes[i]);
	endtask

	task automatic send_section(input int sec_len, input int keep, input int junk);
		int total;
		section_bytes[0].first_byte = 1'b1;
		section_bytes[0].section_length = sec_len[9:0];
		repeat (junk) add_body_byte(rand_byte());
		total = (keep > 0 && keep < section_bytes.size()) ? keep : section_bytes.size();
		send_queued(total);
	endtask

	task automatic random_section();
		int mode;
		int adj;
		mode = $urandom_range(0, 99);
		if (mode < 3) begin
			build_section($urandom_range(5, 10), $urandom_range(0, 60), 40, 1'b0);
			send_section(claimed_len(0), 0, 0);
		end else if (mode < 70) begin
			build_section($urandom_range(0, 4),
				$urandom_range(0, 1) ? 0 : $urandom_range(1, 4), 6, 1'b0);
			send_section(claimed_len(0), 0, 0);
		end else if (mode < 80) begin
			// Claimed length off by a few bytes, with stray bytes after the body.
			build_section($urandom_range(0, 3), $urandom_range(0, 3), 4, 1'b0);
			adj = $urandom_range(1, 6);
			if ($urandom_range(0, 1) == 1) adj = -adj;
			send_section(claimed_len(adj), 0, $urandom_range(0, 6));
		end else if (mode < 87) begin
			// Cut short, so the next first byte restarts the parser mid-section.
			build_section($urandom_range(1, 3), $urandom_range(0, 3), 4, 1'b0);
			send_section(claimed_len(0), $urandom_range(1, section_bytes.size() - 1), 0);
		end else if (mode < 92) begin
			build_section($urandom_range(0, 3), $urandom_range(0, 3), 4, 1'b1);
			send_section(claimed_len(0), 0, $urandom_range(0, 2));
		end else if (mode < 97) begin
			section_bytes = {};
			add_body_byte(rand_byte());
			send_section($urandom_range(0, 12), 0, $urandom_range(0, 3));
		end else begin
			section_bytes = {};
			repeat ($urandom_range(1, 4)) add_body_byte(rand_byte());
			send_queued(section_bytes.size());
		end
	endtask

	task automatic load_type_codes(input logic [7:0] sec, input logic [7:0] priv);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRIV_SECTIONS;
		cfg_data <= sec;
		@(negedge clk);
		cfg_index <= CFG_PRIV_DATA;
		cfg_data <= priv;
		@(negedge clk);
		cfg_we <= 1'b0;
		sections_code = sec;
		private_code = priv;
		settings_used++;
	endtask

	// Waits for every predicted result, then leaves time for a byte that makes none.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			result_ch.ready <= 1'b1;
			ready_hold <= calm ? 0 : $urandom_range(0, 6);
		end else begin
			result_ch.ready <= 1'b0;
			ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int phase_no;
		int phase_start;
		logic [31:0] rnd;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PRIV_SECTIONS;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data = '0;
		result_ch.ready = 1'b0;
		calm = 1'b0;
		sections_code = 8'd5;
		private_code = 8'd6;
		items_sent = 0;
		settings_used = 1;
		idle_cycles = 0;
		ready_hold = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Section too short to hold the PCR PID and descriptor length.
		section_bytes = {};
		add_body_byte(8'hFF);
		send_section(12, 0, 0);
		// A stray byte while idle is ignored.
		section_bytes = {};
		add_body_byte(8'hAA);
		send_queued(1);
		// PCR PID of all ones, then a restart before the descriptor length.
		section_bytes = {};
		add_body_byte(8'hFF);
		add_body_byte(8'hFF);
		send_section(13, 0, 0);
		// Descriptor length of all ones overruns the body.
		section_bytes = {};
		add_body_byte(8'h00);
		add_body_byte(8'h00);
		add_body_byte(8'hFF);
		add_body_byte(8'hFF);
		send_section(13, 0, 0);
		// One sections-class entry whose last byte also ends the body.
		section_bytes = {};
		add_body_byte(8'hE0);
		add_body_byte(8'h00);
		add_body_byte(8'hF0);
		add_body_byte(8'h00);
		add_body_byte(8'h05);
		add_body_byte(8'hFF);
		add_body_byte(8'hFF);
		add_body_byte(8'hF0);
		add_body_byte(8'h00);
		send_section(18, 0, 0);
		// Four bytes left when an entry starts: too few for its header.
		section_bytes = {};
		add_body_byte(8'h00);
		add_body_byte(8'h01);
		add_body_byte(8'h00);
		add_body_byte(8'h00);
		add_body_byte(8'h02);
		send_section(17, 0, 0);
		// One descriptor byte, then a private-data entry whose info overruns.
		section_bytes = {};
		add_body_byte(8'h1F);
		add_body_byte(8'hFF);
		add_body_byte(8'h00);
		add_body_byte(8'h01);
		add_body_byte(8'hAB);
		add_body_byte(8'h06);
		add_body_byte(8'hE0);
		add_body_byte(8'h00);
		add_body_byte(8'h00);
		add_body_byte(8'h01);
		send_section(19, 0, 0);

		for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
			case (phase_no)
			1: load_type_codes(8'h00, 8'hFF);
			2: load_type_codes(8'hFF, 8'h00);
			// Both registers equal: the sections class must win.
			3: load_type_codes(8'h1B, 8'h1B);
			4, 5: begin
				rnd = $urandom;
				load_type_codes(rnd[7:0], rnd[15:8]);
			end
			6: load_type_codes(8'd5, 8'd6);
			default: ;
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) random_section();
			settle();
		end

		$display("Fed %0d section bytes under %0d type-code settings, with restarts,",
			bytes_taken, settings_used);
		$display("short and overrunning lengths mixed in; %0d results checked, %0d errors.",
			results_taken, length_errors);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
